### src/ptzrp_pkg.sv
// ----------------------------------------------------------------------------
// PTZ position reply parser package
// Shared types, frame header codes and the zoom code table.
// ----------------------------------------------------------------------------
package ptzrp_pkg;

  localparam int unsigned WIN_LEN = 6;
  localparam int unsigned FILL_W = 3;
  localparam int unsigned POS_W = 15;
  localparam int unsigned ZOOM_W = 5;
  localparam int unsigned ZOOM_CODES = 30;

  localparam logic [7:0] HDR_BYTE0 = 8'h00;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;
  localparam logic [7:0] HDR_PAN = 8'h09;
  localparam logic [7:0] HDR_TILT = 8'h0A;
  localparam logic [7:0] HDR_ZOOM = 8'hB2;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_PAN  = 2'd0,
    KIND_TILT = 2'd1,
    KIND_ZOOM = 2'd2
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e            kind;
    logic                   checksum_ok;
    logic [POS_W-1:0]       pan;
    logic [POS_W-1:0]       tilt;
    logic [ZOOM_W-1:0]      zoom;
  } ptzrp_result_t;

  typedef struct packed {
    logic              hit;
    logic [ZOOM_W-1:0] step;
  } zoom_lookup_t;

  localparam logic [15:0] ZOOM_CODE_TAB [ZOOM_CODES] = '{
    16'h0000, 16'h1760, 16'h214C, 16'h2722, 16'h2B22, 16'h2E20, 16'h3080, 16'h3278,
    16'h3426, 16'h359E, 16'h36EE, 16'h381C, 16'h392E, 16'h3A26, 16'h3B08, 16'h3BD4,
    16'h3C8C, 16'h3D2E, 16'h4000, 16'h6000, 16'h6A80, 16'h7000, 16'h7300, 16'h7540,
    16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00, 16'h7AC0
  };

  // The table entries are distinct, so at most one compare hits.
  function automatic zoom_lookup_t zoom_lookup(input logic [15:0] code);
    zoom_lookup_t res;
    res.hit = 1'b0;
    res.step = '0;
    for (int i = 0; i < ZOOM_CODES; i++) begin
      if (ZOOM_CODE_TAB[i] == code) begin
        res.hit = 1'b1;
        res.step = ZOOM_W'(i + 1);
      end
    end
    return res;
  endfunction

endpackage

### src/ptzrp_parse_core.sv
// ----------------------------------------------------------------------------
// PTZ reply parse core
// Holds the byte window and the held positions, and decodes one request.
// ----------------------------------------------------------------------------
module ptzrp_parse_core
  import ptzrp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          op_i,
  input  logic [7:0]    data_byte_i,
  output logic          res_valid_o,
  output ptzrp_result_t res_o
);

  logic [7:0]        win_q [WIN_LEN];
  logic [7:0]        win_d [WIN_LEN];
  logic [7:0]        cand [WIN_LEN];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [POS_W-1:0]  pan_q, pan_d;
  logic [POS_W-1:0]  tilt_q, tilt_d;
  logic [ZOOM_W-1:0] zoom_q, zoom_d;
  logic              full;
  logic              hdr_ok;
  frame_kind_e       kind;
  logic [7:0]        sum;
  logic              sum_ok;
  logic [15:0]       code;
  zoom_lookup_t      zl;

  always_comb begin
    for (int i = 0; i < WIN_LEN; i++) begin
      cand[i] = (fill_q == FILL_W'(i)) ? data_byte_i : win_q[i];
    end
  end

  assign full = (fill_q == FILL_W'(WIN_LEN - 1));
  assign sum = cand[0] ^ cand[1] ^ cand[2] ^ cand[3] ^ cand[4];
  assign sum_ok = (sum == cand[5]);
  assign code = {cand[4], cand[3]};
  assign zl = zoom_lookup(code);

  always_comb begin
    hdr_ok = (cand[0] == HDR_BYTE0) && (cand[1] == HDR_BYTE1);
    kind = KIND_PAN;
    case (cand[2])
      HDR_ZOOM: kind = KIND_ZOOM;
      HDR_TILT: kind = KIND_TILT;
      HDR_PAN:  kind = KIND_PAN;
      default:  hdr_ok = 1'b0;
    endcase
  end

  always_comb begin
    win_d = win_q;
    fill_d = fill_q;
    pan_d = pan_q;
    tilt_d = tilt_q;
    zoom_d = zoom_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      if (op_i == OP_CLEAR) begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win_d[i] = '0;
        end
        fill_d = '0;
        pan_d = '0;
        tilt_d = '0;
        zoom_d = '0;
      end else if (!full) begin
        win_d = cand;
        fill_d = fill_q + 1'b1;
      end else if (!hdr_ok) begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
          win_d[i] = cand[i+1];
        end
        win_d[WIN_LEN-1] = '0;
        fill_d = FILL_W'(WIN_LEN - 1);
      end else begin
        for (int i = 0; i < WIN_LEN; i++) begin
          win_d[i] = '0;
        end
        fill_d = '0;
        res_valid_o = 1'b1;
        if (sum_ok) begin
          case (kind)
            KIND_ZOOM: begin
              if (zl.hit) begin
                zoom_d = zl.step;
              end
            end
            KIND_TILT: tilt_d = code[POS_W-1:0];
            default:   pan_d = code[POS_W-1:0];
          endcase
        end
      end
    end
  end

  assign res_o.kind = kind;
  assign res_o.checksum_ok = sum_ok;
  assign res_o.pan = pan_d;
  assign res_o.tilt = tilt_d;
  assign res_o.zoom = zoom_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_q[i] <= '0;
      end
      fill_q <= '0;
      pan_q <= '0;
      tilt_q <= '0;
      zoom_q <= '0;
    end else begin
      win_q <= win_d;
      fill_q <= fill_d;
      pan_q <= pan_d;
      tilt_q <= tilt_d;
      zoom_q <= zoom_d;
    end
  end

endmodule

### src/ptz_position_reply_parser.sv
// ----------------------------------------------------------------------------
// PTZ position reply parser
// Scans camera reply bytes for pan, tilt and zoom frames and reports the
// held positions after each matched frame.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  op_i, data_byte_i
//   out      output     out_valid_o/out_stall_i frame_kind_o, checksum_ok_o,
//                                               pan/tilt_position_o, zoom_step_o
//
// A request is registered in the input register and is decoded from there,
// and its result lands in the output register, from which it is taken.
// One request is taken every cycle while the output is not stalled.
// Reset clears the window, the fill count and the held positions.
// A stalled output holds its result and the input register stalls behind it.
// ----------------------------------------------------------------------------
module ptz_position_reply_parser
  import ptzrp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          frame_kind_o,
  output logic                checksum_ok_o,
  output logic [POS_W-1:0]    pan_position_o,
  output logic [POS_W-1:0]    tilt_position_o,
  output logic [ZOOM_W-1:0]   zoom_step_o
);

  logic          in_valid_q, in_valid_d;
  logic          op_q;
  logic [7:0]    byte_q;
  logic          out_valid_q, out_valid_d;
  ptzrp_result_t res_q;
  ptzrp_result_t res;
  logic          res_valid;
  logic          out_free;
  logic          step;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  ptzrp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .op_i        (op_q),
    .data_byte_i (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q <= op_i;
      byte_q <= data_byte_i;
    end
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frame_kind_o = res_q.kind;
  assign checksum_ok_o = res_q.checksum_ok;
  assign pan_position_o = res_q.pan;
  assign tilt_position_o = res_q.tilt;
  assign zoom_step_o = res_q.zoom;

endmodule

### dv/ptz_position_reply_parser_tb.sv
// ----------------------------------------------------------------------------
// PTZ position reply parser testbench
// Streams directed and random reply bytes into the parser, predicts each
// pan, tilt and zoom report from an independent model of the six-byte
// window and checks every report field by field. The run goes through
// phases of sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ptz_position_reply_parser_tb;
  import ptzrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [15:0] zoom_codes [ZOOM_CODES] = '{
    16'h0000, 16'h1760, 16'h214C, 16'h2722, 16'h2B22, 16'h2E20, 16'h3080, 16'h3278,
    16'h3426, 16'h359E, 16'h36EE, 16'h381C, 16'h392E, 16'h3A26, 16'h3B08, 16'h3BD4,
    16'h3C8C, 16'h3D2E, 16'h4000, 16'h6000, 16'h6A80, 16'h7000, 16'h7300, 16'h7540,
    16'h76C0, 16'h7800, 16'h78C0, 16'h7980, 16'h7A00, 16'h7AC0
  };

  typedef struct {
    op_e        op;
    logic [7:0] data;
  } serial_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              op_i = OP_DATA;
  logic [7:0]        data_byte_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        frame_kind_o;
  logic              checksum_ok_o;
  logic [POS_W-1:0]  pan_position_o;
  logic [POS_W-1:0]  tilt_position_o;
  logic [ZOOM_W-1:0] zoom_step_o;

  serial_req_t       pending_bytes[$];
  ptzrp_result_t     expected_reports[$];

  logic [7:0]        win_q [WIN_LEN];
  int unsigned       fill_q = 0;
  logic [POS_W-1:0]  pan_q = '0;
  logic [POS_W-1:0]  tilt_q = '0;
  logic [ZOOM_W-1:0] zoom_q = '0;

  logic              in_fire = 1'b0;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct = 0;
  logic              long_hold = 1'b0;
  int unsigned       cycle_cnt = 0;
  int unsigned       err_cnt = 0;

  ptz_position_reply_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_kind_o    (frame_kind_o),
    .checksum_ok_o   (checksum_ok_o),
    .pan_position_o  (pan_position_o),
    .tilt_position_o (tilt_position_o),
    .zoom_step_o     (zoom_step_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic track_reply_byte(input logic op, input logic [7:0] rx);
    ptzrp_result_t rep;
    logic [7:0]    sum;
    logic [15:0]   code;
    logic          matched;
    int            i;
    if (op == OP_CLEAR) begin
      pan_q = '0;
      tilt_q = '0;
      zoom_q = '0;
      fill_q = 0;
      win_q = '{default: '0};
      return;
    end
    win_q[fill_q] = rx;
    fill_q++;
    if (fill_q < WIN_LEN) return;
    matched = (win_q[0] == HDR_BYTE0) && (win_q[1] == HDR_BYTE1);
    rep.kind = KIND_PAN;
    if (matched) begin
      case (win_q[2])
        HDR_ZOOM: rep.kind = KIND_ZOOM;
        HDR_TILT: rep.kind = KIND_TILT;
        HDR_PAN:  rep.kind = KIND_PAN;
        default:  matched = 1'b0;
      endcase
    end
    if (!matched) begin
      for (i = 0; i < WIN_LEN - 1; i++) win_q[i] = win_q[i + 1];
      win_q[WIN_LEN - 1] = '0;
      fill_q = WIN_LEN - 1;
      return;
    end
    sum = win_q[0] ^ win_q[1] ^ win_q[2] ^ win_q[3] ^ win_q[4];
    rep.checksum_ok = (sum == win_q[5]);
    code = {win_q[4], win_q[3]};
    if (rep.checksum_ok) begin
      if (rep.kind == KIND_ZOOM) begin
        for (i = 0; i < ZOOM_CODES; i++) begin
          if (zoom_codes[i] == code) zoom_q = ZOOM_W'(i + 1);
        end
      end else if (rep.kind == KIND_TILT) begin
        tilt_q = code[POS_W-1:0];
      end else begin
        pan_q = code[POS_W-1:0];
      end
    end
    rep.pan = pan_q;
    rep.tilt = tilt_q;
    rep.zoom = zoom_q;
    win_q = '{default: '0};
    fill_q = 0;
    expected_reports.push_back(rep);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    ptzrp_result_t rep;
    cycle_cnt <= cycle_cnt + 1;
    in_fire <= in_valid_i && !in_stall_o;
    if (out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report: expected none actual kind %0h", $time,
                 frame_kind_o);
        err_cnt++;
      end else begin
        rep = expected_reports.pop_front();
        check_field("frame_kind", rep.kind, frame_kind_o);
        check_field("checksum_ok", rep.checksum_ok, checksum_ok_o);
        check_field("pan_position", rep.pan, pan_position_o);
        check_field("tilt_position", rep.tilt, tilt_position_o);
        check_field("zoom_step", rep.zoom, zoom_step_o);
      end
    end
    if (in_valid_i && !in_stall_o) track_reply_byte(op_i, data_byte_i);
  end

  always @(negedge clk_i) begin
    serial_req_t req;
    if (!in_valid_i || in_fire) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_bytes.pop_front();
        in_valid_i <= 1'b1;
        op_i <= req.op;
        data_byte_i <= req.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= long_hold || ($urandom_range(99) < stall_pct);
  end

  task automatic push_byte(input op_e op, input logic [7:0] b);
    serial_req_t req;
    req.op = op;
    req.data = b;
    pending_bytes.push_back(req);
  endtask

  function automatic logic [7:0] header_of(input frame_kind_e kind);
    case (kind)
      KIND_ZOOM: return HDR_ZOOM;
      KIND_TILT: return HDR_TILT;
      default:   return HDR_PAN;
    endcase
  endfunction

  task automatic push_frame(input frame_kind_e kind, input logic [15:0] code,
                            input logic good_sum);
    logic [7:0] sum;
    sum = HDR_BYTE0 ^ HDR_BYTE1 ^ header_of(kind) ^ code[7:0] ^ code[15:8];
    if (!good_sum) sum = sum ^ 8'($urandom_range(255, 1));
    push_byte(OP_DATA, HDR_BYTE0);
    push_byte(OP_DATA, HDR_BYTE1);
    push_byte(OP_DATA, header_of(kind));
    push_byte(OP_DATA, code[7:0]);
    push_byte(OP_DATA, code[15:8]);
    push_byte(OP_DATA, sum);
  endtask

  function automatic frame_kind_e random_kind();
    case ($urandom_range(2))
      0:       return KIND_PAN;
      1:       return KIND_TILT;
      default: return KIND_ZOOM;
    endcase
  endfunction

  function automatic logic [15:0] random_code(input frame_kind_e kind);
    if (kind == KIND_ZOOM && $urandom_range(99) < 70)
      return zoom_codes[$urandom_range(ZOOM_CODES - 1)];
    return 16'($urandom);
  endfunction

  // Mostly whole frames; the rest is line noise, clears and cut-off frames.
  task automatic push_random_burst(output int unsigned n);
    int unsigned pick;
    int unsigned len;
    frame_kind_e kind;
    pick = $urandom_range(99);
    kind = random_kind();
    n = 0;
    if (pick < 62) begin
      push_frame(kind, random_code(kind), $urandom_range(99) < 85);
      n = 6;
    end else if (pick < 78) begin
      len = $urandom_range(5, 1);
      repeat (len) begin
        if ($urandom_range(3) == 0) push_byte(OP_DATA, 8'($urandom_range(1)));
        else push_byte(OP_DATA, 8'($urandom));
      end
      n = len;
    end else if (pick < 84) begin
      push_byte(OP_CLEAR, 8'($urandom));
      n = 1;
    end else begin
      len = $urandom_range(5, 3);
      push_byte(OP_DATA, HDR_BYTE0);
      push_byte(OP_DATA, HDR_BYTE1);
      push_byte(OP_DATA, header_of(kind));
      repeat (len - 3) push_byte(OP_DATA, 8'($urandom));
      n = len;
    end
  endtask

  task automatic run_random_phase(input int unsigned target);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < target) begin
      push_random_burst(n);
      sent += n;
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid_i || expected_reports.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    win_q = '{default: '0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_frame(KIND_PAN, 16'hFFFF, 1'b1);
    push_frame(KIND_TILT, 16'h8000, 1'b0);
    push_frame(KIND_ZOOM, 16'h7AC0, 1'b1);
    push_frame(KIND_ZOOM, 16'h1234, 1'b1);
    push_byte(OP_DATA, HDR_BYTE0);
    push_byte(OP_DATA, HDR_BYTE1);
    push_byte(OP_CLEAR, 8'hFF);
    drain();

    run_random_phase(400);
    drain();
    set_idling(69, 0);
    run_random_phase(400);
    drain();
    set_idling(0, 69);
    run_random_phase(400);
    drain();
    set_idling(20, 20);
    run_random_phase(400);
    drain();

    // The sender keeps offering frames while the receiver holds off.
    set_idling(0, 0);
    repeat (60) begin
      frame_kind_e kind;
      kind = random_kind();
      push_frame(kind, random_code(kind), 1'b1);
    end
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    long_hold = 1'b0;
    drain();

    repeat (10) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
